### rtl/core/block_peak_meter_macros.svh
// Assertion macros shared by the peak meter RTL.
`ifndef BLOCK_PEAK_METER_MACROS_SVH
`define BLOCK_PEAK_METER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("peak meter check failed");
// Next-cycle implication.
`define BPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("peak meter check failed");
`else
`define BPM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/core/bpm_pkg.sv
// Constants and register map of the block peak meter.
`timescale 1ns / 1ps
package bpm_pkg;

   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_TIME_BITS    = 48;

   // Configuration register map (index = byte address / 4).
   localparam int CSR_ADDR_W = 4;
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_ENABLE        = 2'd0;
   localparam reg_index_type REG_CHANNEL_COUNT = 2'd1;
   localparam reg_index_type REG_BLOCK_FRAMES  = 2'd2;
   localparam reg_index_type REG_SAMPLE_RATE   = 2'd3;

   // Reset values of the registers.
   localparam logic        RST_ENABLE        = 1'b0;
   localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
   localparam logic [15:0] RST_BLOCK_FRAMES  = 16'd4801;
   localparam int          RST_RATE_INT      = 48000;
   localparam logic [17:0] RST_SAMPLE_RATE   = 18'(RST_RATE_INT);

   // Milliseconds per second, and its split by the reset sample rate.
   localparam int          MS_PER_S_INT = 1000;
   localparam logic [17:0] MS_PER_S     = 18'(MS_PER_S_INT);
   localparam logic [9:0]  RST_MS_QUO   = 10'(MS_PER_S_INT / RST_RATE_INT);
   localparam logic [17:0] RST_MS_REM   = 18'(MS_PER_S_INT % RST_RATE_INT);

   // Restoring divider by the sample rate, one bit of an 18-bit dividend a cycle.
   localparam int                   DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd18;

endpackage

### rtl/core/block_peak_meter.sv
// Block peak meter: per-channel block peak detection on interleaved audio.
//
// Samples arrive on the req_ stream, one signed 16-bit sample per transfer, in
// channel-interleaved order. req_tuser marks the first sample of a call and
// carries the call's base timecode in req_tdata; req_tlast marks the last
// sample of a call and closes any partial frame and block.
// While enabled, each accepted sample is folded into the peak register of its
// channel in the cycle of the transfer, so one sample is taken per cycle while
// req_tready is high. When a block of frames completes, the peaks are copied
// to an emit bank and one result per channel leaves on the rsp_ stream through
// an output register, one transfer per cycle while rsp_tready is high,
// rsp_tlast on the last channel. rsp_tvalid rises once the drain loads
// the first result. req_tready is low while the emit bank drains, so each
// block stalls the input until all its channel results are loaded. A write of
// sample_rate starts a divider that splits 1000 ms, and the remainder held
// from the old rate, by the new rate; req_tready is low while it runs. Reset
// restores the register defaults (disabled, two channels, 4801 frames, 48000
// Hz) and clears the running peaks, counters and time. A stalled rsp_ side
// holds its result; the drain and hence the input wait until it is taken.
`timescale 1ns / 1ps
`include "block_peak_meter_macros.svh"

module block_peak_meter import bpm_pkg::*; #(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int TIME_BITS    = DEF_TIME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // sample stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // [15:0] sample_value, [63:16] base_timecode
   input  logic                  req_tuser,   // [0] call_start
   input  logic                  req_tlast,   // call_end
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // [47:0] block_time, [62:48] peak_level,
                                              // [66:63] channels_in_block, [71:67] zero
   output logic [2:0]            rsp_tuser,   // [2:0] channel_index
   output logic                  rsp_tlast,   // last_channel
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CH_CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // ---------------------------------------------------------------- registers
   logic        enable_ff;
   logic [3:0]  channel_count_ff;
   logic [15:0] block_frames_ff;
   logic [17:0] sample_rate_ff;

   logic        csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= RST_ENABLE;
         channel_count_ff <= RST_CHANNEL_COUNT;
         block_frames_ff  <= RST_BLOCK_FRAMES;
         sample_rate_ff   <= RST_SAMPLE_RATE;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ENABLE:        enable_ff        <= csr_pwdata[0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[3:0];
            REG_BLOCK_FRAMES:  block_frames_ff  <= csr_pwdata[15:0];
            REG_SAMPLE_RATE:   sample_rate_ff   <= csr_pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLE:        csr_prdata = {31'd0, enable_ff};
         REG_CHANNEL_COUNT: csr_prdata = {28'd0, channel_count_ff};
         REG_BLOCK_FRAMES:  csr_prdata = {16'd0, block_frames_ff};
         REG_SAMPLE_RATE:   csr_prdata = {14'd0, sample_rate_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Effective settings: zero values act as one, channels clamp to the limit.
   logic [17:0]         rate_eff;
   logic [15:0]         frames_eff;
   logic [CH_CNT_W-1:0] nch;

   assign rate_eff   = (sample_rate_ff == 18'd0) ? 18'd1 : sample_rate_ff;
   assign frames_eff = (block_frames_ff == 16'd0) ? 16'd1 : block_frames_ff;

   always_comb begin
      if (channel_count_ff == 4'd0)
         nch = CH_CNT_W'(1);
      else if ({1'b0, channel_count_ff} > 5'(MAX_CHANNELS))
         nch = CH_CNT_W'(MAX_CHANNELS);
      else
         nch = CH_CNT_W'(channel_count_ff);
   end

   // ----------------------------------------------- 1000 / rate, one bit a cycle
   // The per-frame step then needs only a single compare and subtract.
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [17:0]          ms_rem_step_ff;   // 1000 mod rate
   logic [9:0]           ms_quo_step_ff;   // 1000 div rate
   logic [DIV_CNT_W-1:0] div_bit_idx;
   logic [18:0]          div_trial;
   logic                 div_busy;

   assign div_busy    = (div_cnt_ff != '0);
   assign div_bit_idx = DIV_CNT_W'(div_cnt_ff - DIV_CNT_W'(1));
   assign div_trial   = {ms_rem_step_ff, MS_PER_S[div_bit_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff     <= '0;
         ms_rem_step_ff <= RST_MS_REM;
         ms_quo_step_ff <= RST_MS_QUO;
      end else if (csr_wr && csr_idx == REG_SAMPLE_RATE) begin
         div_cnt_ff     <= DIV_STEPS;
         ms_rem_step_ff <= '0;
         ms_quo_step_ff <= '0;
      end else if (div_busy) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         if (div_trial >= {1'b0, rate_eff}) begin
            ms_rem_step_ff <= 18'(div_trial - {1'b0, rate_eff});
            ms_quo_step_ff <= {ms_quo_step_ff[8:0], 1'b1};
         end else begin
            ms_rem_step_ff <= div_trial[17:0];
            ms_quo_step_ff <= {ms_quo_step_ff[8:0], 1'b0};
         end
      end
   end

   // ------------------------------------------------------------- sample path
   logic [14:0]          peaks_ff [MAX_CHANNELS];
   logic [CH_IDX_W-1:0]  cur_ff;
   logic [15:0]          frames_ff;
   logic [TIME_BITS-1:0] base_time_ff;
   logic [TIME_BITS-1:0] elapsed_ff;
   logic [17:0]          ms_rem_ff;
   logic [TIME_BITS-1:0] block_start_ff;

   logic [14:0]          emit_peaks_ff [MAX_CHANNELS];
   logic [TIME_BITS-1:0] emit_time_ff;
   logic [CH_CNT_W-1:0]  emit_nch_ff;
   logic [CH_IDX_W-1:0]  emit_idx_ff;
   logic                 emit_busy_ff;

   logic                 req_fire;
   logic                 call_start;
   logic                 call_end;
   logic [15:0]          sample_value;
   logic [TIME_BITS-1:0] base_in;

   assign req_tready   = !emit_busy_ff && !div_busy;
   assign req_fire     = req_tvalid && req_tready;
   assign sample_value = req_tdata[15:0];
   assign base_in      = TIME_BITS'(req_tdata[63:16]);
   assign call_start   = req_tuser;
   assign call_end     = req_tlast;

   // State as seen after the call start clear.
   logic [TIME_BITS-1:0] base_b;
   logic [TIME_BITS-1:0] elapsed_b;
   logic [17:0]          ms_rem_b;
   logic [TIME_BITS-1:0] block_start_b;
   logic [15:0]          frames_b;
   logic [CH_IDX_W-1:0]  cur_s;
   logic [CH_IDX_W-1:0]  cur_b;
   logic [14:0]          peaks_b [MAX_CHANNELS];
   logic [14:0]          peak_old;
   logic [14:0]          mag;
   logic [15:0]          neg_value;
   logic [14:0]          peak_new;
   logic [CH_CNT_W-1:0]  cur_next;
   logic                 frame_done;
   logic                 use_norm;
   logic [17:0]          rem_base;
   logic [18:0]          rem_sum;
   logic                 rem_carry;
   logic [9:0]           ms_step;
   logic [TIME_BITS-1:0] elapsed_n;
   logic [17:0]          ms_rem_n;
   logic [15:0]          frames_n;
   logic                 emit_now;
   logic [14:0]          peaks_upd [MAX_CHANNELS];

   // ------------------------------------ remainder held across a rate change
   // The remainder left by the old rate can exceed the new one. It is split by
   // the new rate alongside 1000, and the split is used at the next frame end.
   logic [17:0] norm_rem_ff;
   logic [17:0] norm_quo_ff;
   logic        norm_pend_ff;
   logic [18:0] norm_trial;
   logic        norm_take;

   assign norm_trial = {norm_rem_ff, ms_rem_ff[div_bit_idx]};
   assign norm_take  = (norm_trial >= {1'b0, rate_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_rem_ff  <= 18'd0;
         norm_quo_ff  <= 18'd0;
         norm_pend_ff <= 1'b0;
      end else if (csr_wr && csr_idx == REG_SAMPLE_RATE) begin
         norm_rem_ff  <= 18'd0;
         norm_quo_ff  <= 18'd0;
         norm_pend_ff <= 1'b1;
      end else if (div_busy) begin
         norm_rem_ff <= norm_take ? 18'(norm_trial - {1'b0, rate_eff}) : norm_trial[17:0];
         norm_quo_ff <= {norm_quo_ff[16:0], norm_take};
      end else if (req_fire && (call_start || (enable_ff && frame_done))) begin
         norm_pend_ff <= 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         peaks_b[i] = call_start ? 15'd0 : peaks_ff[i];
      end
      base_b        = call_start ? base_in : base_time_ff;
      elapsed_b     = call_start ? '0 : elapsed_ff;
      ms_rem_b      = call_start ? 18'd0 : ms_rem_ff;
      block_start_b = call_start ? '0 : block_start_ff;
      frames_b      = call_start ? 16'd0 : frames_ff;
      cur_s         = call_start ? '0 : cur_ff;
      cur_b         = cur_s;
      // A lowered channel count restarts the frame at channel zero.
      if (CH_CNT_W'(cur_b) >= nch)
         cur_b = '0;

      peak_old = peaks_b[cur_b];

      // Magnitude; the most negative sample saturates.
      neg_value = 16'(~sample_value + 16'd1);
      if (!sample_value[15])
         mag = sample_value[14:0];
      else if (sample_value == 16'h8000)
         mag = 15'h7FFF;
      else
         mag = neg_value[14:0];
      peak_new = (mag > peak_old) ? mag : peak_old;

      peaks_upd        = peaks_b;
      peaks_upd[cur_b] = peak_new;

      cur_next   = CH_CNT_W'(cur_b) + CH_CNT_W'(1);
      frame_done = (cur_next >= nch) || call_end;

      // Elapsed time moves by 1000/rate ms per frame, carried as quotient
      // and remainder.
      use_norm  = norm_pend_ff && !call_start;
      rem_base  = use_norm ? norm_rem_ff : ms_rem_b;
      rem_sum   = {1'b0, rem_base} + {1'b0, ms_rem_step_ff};
      rem_carry = (rem_sum >= {1'b0, rate_eff});
      ms_step   = ms_quo_step_ff + {9'd0, rem_carry};
      ms_rem_n  = rem_carry ? 18'(rem_sum - {1'b0, rate_eff}) : rem_sum[17:0];
      elapsed_n = elapsed_b + TIME_BITS'(ms_step) +
                  (use_norm ? TIME_BITS'(norm_quo_ff) : TIME_BITS'(0));
      frames_n  = frames_b + 16'd1;

      emit_now = frame_done && ((frames_n >= frames_eff) || call_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            peaks_ff[i] <= 15'd0;
         end
         cur_ff         <= '0;
         frames_ff      <= 16'd0;
         base_time_ff   <= '0;
         elapsed_ff     <= '0;
         ms_rem_ff      <= 18'd0;
         block_start_ff <= '0;
      end else if (req_fire) begin
         base_time_ff <= base_b;
         if (enable_ff) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               peaks_ff[i] <= emit_now ? 15'd0 : peaks_upd[i];
            end
            if (emit_now) begin
               frames_ff      <= 16'd0;
               block_start_ff <= elapsed_n;
            end else begin
               frames_ff      <= frame_done ? frames_n : frames_b;
               block_start_ff <= block_start_b;
            end
            if (frame_done) begin
               cur_ff     <= '0;
               elapsed_ff <= elapsed_n;
               ms_rem_ff  <= ms_rem_n;
            end else begin
               cur_ff     <= cur_next[CH_IDX_W-1:0];
               elapsed_ff <= elapsed_b;
               ms_rem_ff  <= ms_rem_b;
            end
         end else begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               peaks_ff[i] <= peaks_b[i];
            end
            cur_ff         <= cur_s;
            frames_ff      <= frames_b;
            elapsed_ff     <= elapsed_b;
            ms_rem_ff      <= ms_rem_b;
            block_start_ff <= block_start_b;
         end
      end
   end

   // ------------------------------------------------------ emit bank and drain
   logic emit_fire;
   logic rsp_load;
   logic emit_last;

   assign emit_fire = req_fire && enable_ff && emit_now;
   assign emit_last = (CH_CNT_W'(emit_idx_ff) + CH_CNT_W'(1)) == emit_nch_ff;

   logic                 rsp_valid_ff;
   logic [47:0]          rsp_time_ff;
   logic [2:0]           rsp_chan_ff;
   logic [14:0]          rsp_peak_ff;
   logic [3:0]           rsp_nch_ff;
   logic                 rsp_last_ff;
   logic [63:0]          time_wide;

   assign rsp_load  = emit_busy_ff && (!rsp_valid_ff || rsp_tready);
   assign time_wide = 64'(emit_time_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else if (emit_fire) begin
         emit_busy_ff <= 1'b1;
         emit_idx_ff  <= '0;
      end else if (rsp_load) begin
         emit_busy_ff <= !emit_last;
         emit_idx_ff  <= emit_last ? '0 : CH_IDX_W'(emit_idx_ff + CH_IDX_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         emit_peaks_ff <= peaks_upd;
         emit_time_ff  <= base_b + block_start_b;
         emit_nch_ff   <= nch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_time_ff <= time_wide[47:0];
         rsp_chan_ff <= 3'(emit_idx_ff);
         rsp_peak_ff <= emit_peaks_ff[emit_idx_ff];
         rsp_nch_ff  <= 4'(emit_nch_ff);
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_nch_ff, rsp_peak_ff, rsp_time_ff};
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ----------------------------------------------------------------- checks
   `BPM_ASSERT_NEXT(a_emit_starts_drain, clock, reset, emit_fire, emit_busy_ff)
   `BPM_ASSERT_IMP(a_drain_index_in_range, clock, reset, emit_busy_ff,
                   CH_CNT_W'(emit_idx_ff) < emit_nch_ff)
   `BPM_ASSERT_IMP(a_last_matches_count, clock, reset, rsp_valid_ff && rsp_last_ff,
                   ({2'b00, rsp_chan_ff} + 5'd1) == {1'b0, rsp_nch_ff})
   `BPM_ASSERT_IMP(a_channel_in_range, clock, reset, 1'b1,
                   32'(cur_ff) < 32'(MAX_CHANNELS))

endmodule

### dv/block_peak_meter_test.sv
// Self-checking testbench for the block peak meter: directed and random sample streams.
`timescale 1ns / 1ps

module block_peak_meter_test;
   import bpm_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [47:0] block_time;
      logic [2:0]  channel;
      logic [14:0] peak;
      logic [3:0]  channels;
      logic        last_ch;
   } peak_report_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [15:0] sample_value, [63:16] base_timecode
   logic        req_tuser;   // [0] call_start
   logic        req_tlast;   // call_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // [47:0] block_time, [62:48] peak_level,
                             // [66:63] channels_in_block, [71:67] zero
   logic [2:0]  rsp_tuser;   // [2:0] channel_index
   logic        rsp_tlast;   // last_channel
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Shadow of the configuration registers.
   logic        cfg_enable   = RST_ENABLE;
   logic [3:0]  cfg_channels = RST_CHANNEL_COUNT;
   logic [15:0] cfg_frames   = RST_BLOCK_FRAMES;
   logic [17:0] cfg_rate     = RST_SAMPLE_RATE;

   // Shadow of the meter's running state.
   logic [14:0] peak_hold [DEF_MAX_CHANNELS] = '{default: '0};
   int          chan_pos   = 0;
   logic [15:0] frame_cnt  = '0;
   logic [47:0] call_base  = '0;
   logic [47:0] elapsed    = '0;
   logic [17:0] ms_rem     = '0;
   logic [47:0] blk_start  = '0;

   peak_report_type pending_reports[$];

   int failures       = 0;
   int samples_sent   = 0;
   int reports_seen   = 0;
   int configurations = 0;
   int idle_cycles    = 0;
   int max_gap        = 8;
   int max_stall      = 8;

   block_peak_meter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void clear_peaks();
      peak_hold = '{default: '0};
      frame_cnt = '0;
      blk_start = elapsed;
   endfunction

   function automatic void emit_peaks(int nch);
      logic [47:0]     stamp;
      peak_report_type rpt;
      stamp = call_base + blk_start;
      for (int c = 0; c < nch; c++) begin
         rpt.block_time = stamp;
         rpt.channel    = 3'(c);
         rpt.peak       = peak_hold[c];
         rpt.channels   = 4'(nch);
         rpt.last_ch    = (c == nch - 1);
         pending_reports.insert(pending_reports.size(), rpt);
      end
      clear_peaks();
   endfunction

   // Folds one accepted sample into the shadow state and queues any block it closes.
   function automatic void fold_sample(logic [15:0] raw, bit call_start,
                                       logic [47:0] base, bit call_end);
      int nch;
      int frames_needed;
      int mag;
      longint unsigned acc;
      longint unsigned rate;
      if (call_start) begin
         call_base = base;
         elapsed   = '0;
         ms_rem    = '0;
         chan_pos  = 0;
         clear_peaks();
      end
      if (!cfg_enable) return;
      nch = (cfg_channels == 0) ? 1 :
            (cfg_channels > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : int'(cfg_channels);
      frames_needed = (cfg_frames == 0) ? 1 : int'(cfg_frames);
      if (chan_pos >= nch) chan_pos = 0;
      // The magnitude of the most negative sample saturates to the largest positive one.
      mag = raw[15] ? 65536 - int'(raw) : int'(raw);
      if (mag > 32767) mag = 32767;
      if (mag > int'(peak_hold[chan_pos])) peak_hold[chan_pos] = 15'(mag);
      chan_pos++;
      if (chan_pos >= nch || call_end) begin
         rate = (cfg_rate == 0) ? 1 : longint'(cfg_rate);
         acc = longint'(ms_rem) + MS_PER_S_INT;
         elapsed = elapsed + 48'(acc / rate);
         ms_rem = 18'(acc % rate);
         chan_pos = 0;
         frame_cnt = frame_cnt + 16'd1;
         if (int'(frame_cnt) >= frames_needed) begin
            emit_peaks(nch);
            return;
         end
      end
      if (call_end && frame_cnt > 0) emit_peaks(nch);
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   task automatic send_sample(input logic [15:0] sample, input bit call_start,
                              input logic [47:0] base, input bit call_end);
      int gap;
      gap = $urandom_range(0, max_gap);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {base, sample};
      req_tuser  <= call_start;
      req_tlast  <= call_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      samples_sent++;
      fold_sample(sample, call_start, base, call_end);
   endtask

   // Lets the meter run dry: every queued report taken and the pipeline quiet.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_reports.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_ENABLE:        cfg_enable   = value[0];
         REG_CHANNEL_COUNT: cfg_channels = value[3:0];
         REG_BLOCK_FRAMES:  cfg_frames   = value[15:0];
         REG_SAMPLE_RATE:   cfg_rate     = value[17:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // The sample rate goes last, as its write sets the divider off.
   task automatic configure(input bit en, input int channels, input int frames,
                            input int rate);
      settle();
      csr_write(REG_ENABLE, 32'(en));
      csr_write(REG_CHANNEL_COUNT, 32'(channels));
      csr_write(REG_BLOCK_FRAMES, 32'(frames));
      csr_write(REG_SAMPLE_RATE, 32'(rate));
      configurations++;
   endtask

   task automatic test_disabled_call();
      // Out of reset the meter is off; the call start still loads the time base.
      send_sample(16'h8000, 1'b1, 48'h1234_5678_9ABC, 1'b0);
      send_sample(16'h7FFF, 1'b0, 48'h0, 1'b0);
      send_sample(16'h0001, 1'b0, 48'h0, 1'b1);
      settle();
   endtask

   task automatic test_peak_extremes();
      configure(1'b1, 2, 2, 48000);
      send_sample(16'h8000, 1'b1, 48'h0, 1'b0);
      send_sample(16'h0005, 1'b0, 48'h0, 1'b0);
      send_sample(16'h8001, 1'b0, 48'h0, 1'b0);
      send_sample(16'hFFFF, 1'b0, 48'h0, 1'b0);
      // Start and end together: a one-sample call closes a partial frame and block.
      send_sample(16'h4000, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1);
      settle();
   endtask

   task automatic test_channel_count_edges();
      configure(1'b1, 3, 1, 48000);
      send_sample(16'h1111, 1'b1, 48'h0000_0000_1000, 1'b0);
      send_sample(16'hEEEE, 1'b0, 48'h0, 1'b0);
      // Lowering the count mid-frame restarts the frame at channel zero; its peaks stay.
      settle();
      csr_write(REG_CHANNEL_COUNT, 32'd2);
      send_sample(16'h2222, 1'b0, 48'h0, 1'b0);
      send_sample(16'hDDDD, 1'b0, 48'h0, 1'b0);
      // Zero counts, frames and rate all act as one; the stamp wraps past the top.
      configure(1'b1, 0, 0, 0);
      send_sample(16'h0F0F, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
      send_sample(16'hF0F0, 1'b0, 48'h0, 1'b0);
      // An oversized count is clamped to the channel limit.
      configure(1'b1, 15, 1, 999);
      for (int i = 0; i < 8; i++) begin
         send_sample(16'($urandom), i == 0, 48'h5555_AAAA_5555, 1'b0);
      end
      // A call without a start marker carries the previous call's time on.
      send_sample(16'h7FFE, 1'b0, 48'hAAAA_5555_AAAA, 1'b1);
      settle();
   endtask

   task automatic test_random_calls();
      int target;
      int len;
      int channels;
      int frames;
      int rate;
      bit tidy;
      bit call_start;
      bit call_end;
      logic [15:0] sample;
      logic [47:0] base;
      target = samples_sent + 100;
      while (samples_sent < target) begin
         channels = $urandom_range(0, 15);
         case ($urandom_range(0, 5))
            0:       frames = 0;
            1:       frames = 65535;
            default: frames = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 7))
            0:       rate = 0;
            1:       rate = 1;
            2:       rate = 999;
            3:       rate = 1000;
            4:       rate = 192000;
            5:       rate = 18'h3FFFF;
            6:       rate = 44100;
            default: rate = $urandom_range(1000, 192000);
         endcase
         configure($urandom_range(0, 9) != 0, channels, frames, rate);
         max_gap   = 8 * $urandom_range(0, 1);
         max_stall = 8 * $urandom_range(0, 1);
         repeat ($urandom_range(1, 4)) begin
            len  = $urandom_range(1, 24);
            // Most calls are well-formed; the rest carry markers at random places.
            tidy = $urandom_range(0, 9) < 8;
            for (int i = 0; i < len; i++) begin
               call_start = tidy ? (i == 0) : ($urandom_range(0, 7) == 0);
               call_end   = tidy ? (i == len - 1) : ($urandom_range(0, 7) == 0);
               case ($urandom_range(0, 7))
                  0:       sample = 16'h8000;
                  1:       sample = 16'h7FFF;
                  default: sample = 16'($urandom);
               endcase
               if ($urandom_range(0, 3) == 0)
                  base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4000));
               else
                  base = {16'($urandom), 32'($urandom)};
               send_sample(sample, call_start, base, call_end);
            end
         end
      end
   endtask

   // Result side: a fresh stall is drawn before each report is taken.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = $urandom_range(0, max_stall);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      peak_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $error("peak report with none expected: time %0h channel %0d peak %0d",
                   rsp_tdata[47:0], rsp_tuser, rsp_tdata[62:48]);
            failures++;
         end else begin
            want = pending_reports[0];
            pending_reports.delete(0);
            check_field("block_time", want.block_time, rsp_tdata[47:0]);
            check_field("channel_index", want.channel, rsp_tuser);
            check_field("peak_level", want.peak, rsp_tdata[62:48]);
            check_field("channels_in_block", want.channels, rsp_tdata[66:63]);
            check_field("last_channel", want.last_ch, rsp_tlast);
         end
      end
   end

   // Watchdog: any transfer on any port counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d reports outstanding",
                  idle_cycles, pending_reports.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_disabled_call();
      test_peak_extremes();
      test_channel_count_edges();
      test_random_calls();
      settle();

      if (pending_reports.size() != 0) begin
         $error("%0d peak reports never arrived", pending_reports.size());
         failures++;
      end
      $display("%0d samples metered over %0d register settings, %0d peak reports checked",
               samples_sent, configurations, reports_seen);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
